// ----- rtl/core/plk_pkg.sv -----
// shared widths and constants of the per-key load ranker
`default_nettype none

package plk_pkg;

  // field widths
  localparam int LIGHT_W  = 3;
  localparam int CARS_W   = 8;
  localparam int TOTAL_W  = 24;
  localparam int PERIOD_W = 8;

  // number of ranks carried by one report
  localparam int REPORT_RANKS = 4;

  // saturation value of a running total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // report period after reset
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd48;

endpackage

`default_nettype wire

// ----- rtl/core/plk_rec_if.sv -----
// record channel: light identifier and car count
`default_nettype none

interface plk_rec_if
  import plk_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIGHT_W-1:0] lamp_id;
  logic [CARS_W-1:0]  cars;

  modport source (output valid, output lamp_id, output cars, input ready);
  modport sink   (input valid, input lamp_id, input cars, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/plk_rank_if.sv -----
// report channel: four ranked lights with their totals
`default_nettype none

interface plk_rank_if
  import plk_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIGHT_W-1:0] first_light;
  logic [TOTAL_W-1:0] first_cars;
  logic [LIGHT_W-1:0] second_light;
  logic [TOTAL_W-1:0] second_cars;
  logic [LIGHT_W-1:0] third_light;
  logic [TOTAL_W-1:0] third_cars;
  logic [LIGHT_W-1:0] fourth_light;
  logic [TOTAL_W-1:0] fourth_cars;

  modport source (
    output valid, output first_light, output first_cars, output second_light,
    output second_cars, output third_light, output third_cars,
    output fourth_light, output fourth_cars, input ready
  );
  modport sink (
    input valid, input first_light, input first_cars, input second_light,
    input second_cars, input third_light, input third_cars,
    input fourth_light, input fourth_cars, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/plk_cfg_if.sv -----
// configuration write channel for the report period
`default_nettype none

interface plk_cfg_if
  import plk_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] report_period;

  modport source (output valid, output report_period, input ready);
  modport sink   (input valid, input report_period, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/plk_ranker.sv -----
// stable descending rank network over the light totals
`default_nettype none

module plk_ranker
  import plk_pkg::*;
#(
  parameter int NUM_LIGHTS = 4,
  parameter int IDX_W      = $clog2(NUM_LIGHTS)
) (
  input  logic [TOTAL_W-1:0] totals_i [NUM_LIGHTS],
  input  logic [IDX_W-1:0]   order_i  [NUM_LIGHTS],
  output logic [IDX_W-1:0]   order_o  [NUM_LIGHTS]
);

  logic [TOTAL_W-1:0] pos_total [NUM_LIGHTS];
  logic [IDX_W-1:0]   pos_rank  [NUM_LIGHTS];

  // totals seen in previous rank order
  always_comb begin
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      pos_total[i] = totals_i[order_i[i]];
    end
  end

  // new rank: larger totals ahead, equal totals keep their old order
  always_comb begin
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      pos_rank[i] = '0;
      for (int j = 0; j < NUM_LIGHTS; j++) begin
        if (j != i) begin
          if ((pos_total[j] > pos_total[i]) ||
              ((j < i) && (pos_total[j] == pos_total[i]))) begin
            pos_rank[i] = pos_rank[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  // scatter each light to its rank slot
  always_comb begin
    for (int k = 0; k < NUM_LIGHTS; k++) begin
      order_o[k] = '0;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        if (pos_rank[i] == IDX_W'(k)) begin
          order_o[k] = order_i[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/per_key_load_ranker.sv -----
// Per-light running car totals with a periodic stable ranking report.
// Records pass the input register; their reports then enter the result register.
// Throughput: one record per cycle unless stalled; ranking and accumulate share one stage.
// A record that triggers a report waits only while a full result register is not read.
// Reset: totals zero, rank order lights 1..NUM_LIGHTS, row counter zero, period 48.
`default_nettype none

module per_key_load_ranker
  import plk_pkg::*;
#(
  parameter int NUM_LIGHTS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  plk_cfg_if.sink    cfg_i,
  plk_rec_if.sink    rec_i,
  plk_rank_if.source rank_o
);

  localparam int IDX_W = $clog2(NUM_LIGHTS);

  // input register
  logic               in_vld_q;
  logic [LIGHT_W-1:0] id_q;
  logic [CARS_W-1:0]  cars_q;

  // block state
  logic [TOTAL_W-1:0]  totals_q [NUM_LIGHTS];
  logic [IDX_W-1:0]    order_q  [NUM_LIGHTS];
  logic [PERIOD_W-1:0] row_cnt_q;
  logic [PERIOD_W-1:0] period_q;

  // result register
  logic               out_vld_q;
  logic [LIGHT_W-1:0] res_light_q [REPORT_RANKS];
  logic [TOTAL_W-1:0] res_cars_q  [REPORT_RANKS];

  logic               hit;
  logic [IDX_W-1:0]   sel_idx;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_total;
  logic [TOTAL_W-1:0] totals_d [NUM_LIGHTS];
  logic [IDX_W-1:0]   order_d  [NUM_LIGHTS];
  logic [PERIOD_W:0]  row_next;
  logic [PERIOD_W:0]  period_eff;
  logic               report_due;
  logic               advance;
  logic [LIGHT_W-1:0] res_light_d [REPORT_RANKS];
  logic [TOTAL_W-1:0] res_cars_d  [REPORT_RANKS];

  // accumulate the registered record into its light's total
  assign hit       = (id_q != '0) && (int'(id_q) <= NUM_LIGHTS);
  assign sel_idx   = IDX_W'(id_q - LIGHT_W'(1));
  assign sum       = {1'b0, totals_q[sel_idx]} + (TOTAL_W + 1)'(cars_q);
  assign sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      totals_d[i] = (hit && (sel_idx == IDX_W'(i))) ? sat_total : totals_q[i];
    end
  end

  // row counting; a zero period means the full counter range
  assign row_next   = {1'b0, row_cnt_q} + (PERIOD_W + 1)'(1);
  assign period_eff = (period_q == '0) ? (PERIOD_W + 1)'(1 << PERIOD_W)
                                       : {1'b0, period_q};
  assign report_due = (row_next >= period_eff);

  // the stage moves unless a report meets a full result register that is not being read
  assign advance     = in_vld_q && (!report_due || !out_vld_q || rank_o.ready);
  assign rec_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // ranking of the updated totals
  plk_ranker #(
    .NUM_LIGHTS (NUM_LIGHTS),
    .IDX_W      (IDX_W)
  ) u_ranker (
    .totals_i (totals_d),
    .order_i  (order_q),
    .order_o  (order_d)
  );

  // report fields; ranks without a light stay zero
  for (genvar k = 0; k < REPORT_RANKS; k++) begin : g_res
    if (k < NUM_LIGHTS) begin : g_used
      assign res_light_d[k] = LIGHT_W'(int'(order_d[k]) + 1);
      assign res_cars_d[k]  = totals_d[order_d[k]];
    end else begin : g_empty
      assign res_light_d[k] = '0;
      assign res_cars_d[k]  = '0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rec_i.valid && rec_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.valid && rec_i.ready) begin
      id_q   <= rec_i.lamp_id;
      cars_q <= rec_i.cars;
    end
  end

  // totals, rank order, row counter and period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        totals_q[i] <= '0;
        order_q[i]  <= IDX_W'(i);
      end
      row_cnt_q <= '0;
      period_q  <= PERIOD_RESET;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        period_q <= cfg_i.report_period;
      end
      if (advance) begin
        totals_q <= totals_d;
        if (report_due) begin
          order_q   <= order_d;
          row_cnt_q <= '0;
        end else begin
          row_cnt_q <= row_next[PERIOD_W-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && report_due) begin
      out_vld_q <= 1'b1;
    end else if (rank_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && report_due) begin
      res_light_q <= res_light_d;
      res_cars_q  <= res_cars_d;
    end
  end

  // drive the report channel
  assign rank_o.valid        = out_vld_q;
  assign rank_o.first_light  = res_light_q[0];
  assign rank_o.first_cars   = res_cars_q[0];
  assign rank_o.second_light = res_light_q[1];
  assign rank_o.second_cars  = res_cars_q[1];
  assign rank_o.third_light  = res_light_q[2];
  assign rank_o.third_cars   = res_cars_q[2];
  assign rank_o.fourth_light = res_light_q[3];
  assign rank_o.fourth_cars  = res_cars_q[3];

endmodule

`default_nettype wire
